// ----- rtl/core/ppubm_pkg.sv -----
// shared types and constants for the ppu video-bus memory map
package ppubm_pkg;

  localparam int BUS_W         = 14;
  localparam int PATTERN_DEPTH = 8192;
  localparam int NT_DEPTH      = 2048;
  localparam int PALETTE_DEPTH = 32;
  localparam int NT_SIZE       = 1024;
  localparam int PATTERN_AW    = $clog2(PATTERN_DEPTH);
  localparam int NT_AW         = $clog2(NT_DEPTH);
  localparam int PALETTE_AW    = $clog2(PALETTE_DEPTH);
  localparam int NT_OFS_W      = $clog2(NT_SIZE);

  localparam logic [BUS_W-1:0] PALETTE_BASE = 14'h3f00;
  localparam logic [BUS_W-1:0] FOLD_BASE    = 14'h3000;
  localparam logic [BUS_W-1:0] FOLD_STEP    = 14'h1000;
  localparam logic [BUS_W-1:0] NT_BASE      = 14'h2000;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [1:0] {
    REGION_PATTERN,
    REGION_NAMETABLE,
    REGION_PALETTE
  } region_t;

  typedef struct packed {
    region_t                region;
    logic [PATTERN_AW-1:0]  pattern_addr;
    logic [NT_AW-1:0]       nt_addr;
    logic [PALETTE_AW-1:0]  palette_addr;
  } decode_t;

endpackage

// ----- rtl/core/ppubm_ram.sv -----
// generic single-port synchronous ram with registered read data
module ppubm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/core/ppubm_decode.sv -----
// address fold and region decode for the video bus
module ppubm_decode (
  input  logic               vertical_mirroring,
  input  logic [15:0]        address,
  output ppubm_pkg::decode_t dec
);

  logic [ppubm_pkg::BUS_W-1:0] bus_addr;
  logic [ppubm_pkg::BUS_W-1:0] folded;
  logic [1:0]                  quadrant;
  logic                        nt_table;

  always_comb begin
    bus_addr = address[ppubm_pkg::BUS_W-1:0];
    // mirror of the nametable region
    if (bus_addr >= ppubm_pkg::FOLD_BASE) begin
      folded = bus_addr - ppubm_pkg::FOLD_STEP;
    end else begin
      folded = bus_addr;
    end
    quadrant = folded[ppubm_pkg::NT_OFS_W+1:ppubm_pkg::NT_OFS_W];
    nt_table = vertical_mirroring ? quadrant[0] : quadrant[1];

    dec.pattern_addr = folded[ppubm_pkg::PATTERN_AW-1:0];
    dec.nt_addr      = {nt_table, folded[ppubm_pkg::NT_OFS_W-1:0]};
    dec.palette_addr = bus_addr[ppubm_pkg::PALETTE_AW-1:0];

    priority if (bus_addr >= ppubm_pkg::PALETTE_BASE) begin
      dec.region = ppubm_pkg::REGION_PALETTE;
    end else if (folded >= ppubm_pkg::NT_BASE) begin
      dec.region = ppubm_pkg::REGION_NAMETABLE;
    end else begin
      dec.region = ppubm_pkg::REGION_PATTERN;
    end
  end

endmodule

// ----- rtl/core/ppu_bus_memory_map.sv -----
// top level of the ppu video-bus memory map
//
// input channel: in_valid / in_stall carry one transaction per cycle unless
//   stalled, with req_type (0 read, 1 write), 16-bit address and write_data
// output channel: out_valid / out_stall carry read_data, one per read;
//   writes produce nothing on the output
// address folds modulo 0x4000; 0x3000-0x3eff mirrors down by 0x1000,
//   0x3f00 and up hits 32 palette bytes, 0x2000-0x2fff hits two 1 KiB
//   nametables chosen by vertical_mirroring, below 0x2000 the pattern store
// throughput: one transaction per unstalled cycle, set by the single port
//   of each store; a read and a write never touch a port in the same cycle
// read path: an accepted read is registered in its store's ram, then moves
//   into the output register once that register is free
// stall: the ram read-data register acts as a skid stage, so one more
//   transaction is taken while a result waits; in_stall rises only when
//   both the output register and the pending read are full
// reset: clears the valid flags and vertical_mirroring (horizontal);
//   store contents are undefined until written and need no clearing
// cfg_write_en loads vertical_mirroring; write only while idle
module ppu_bus_memory_map (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        vertical_mirroring,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data
);

  // mirroring register
  logic mirror_vert;

  // decoded address of the incoming transaction
  ppubm_pkg::decode_t dec;

  logic accept;
  logic is_read;
  logic is_write;

  // pending read: the ram output registers hold its data
  logic                 rd_pend;
  ppubm_pkg::region_t   rd_region;
  logic                 move;

  logic [7:0] pattern_q;
  logic [7:0] nt_q;
  logic [7:0] palette_q;
  logic [7:0] rd_mux;

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_vert <= 1'b0;
    end else if (cfg_write_en) begin
      mirror_vert <= vertical_mirroring;
    end
  end

  ppubm_decode u_decode (
    .vertical_mirroring (mirror_vert),
    .address            (address),
    .dec                (dec)
  );

  // hold off only when both the skid and the output register are full
  assign in_stall = rd_pend && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_read  = accept && (req_type == ppubm_pkg::REQ_READ);
  assign is_write = accept && (req_type == ppubm_pkg::REQ_WRITE);
  assign move     = rd_pend && (!out_valid || !out_stall);

  ppubm_ram #(
    .DEPTH (ppubm_pkg::PATTERN_DEPTH),
    .WIDTH (8)
  ) u_pattern (
    .clk   (clk),
    .wr_en (is_write && (dec.region == ppubm_pkg::REGION_PATTERN)),
    .rd_en (is_read && (dec.region == ppubm_pkg::REGION_PATTERN)),
    .addr  (dec.pattern_addr),
    .wdata (write_data),
    .rdata (pattern_q)
  );

  ppubm_ram #(
    .DEPTH (ppubm_pkg::NT_DEPTH),
    .WIDTH (8)
  ) u_nametable (
    .clk   (clk),
    .wr_en (is_write && (dec.region == ppubm_pkg::REGION_NAMETABLE)),
    .rd_en (is_read && (dec.region == ppubm_pkg::REGION_NAMETABLE)),
    .addr  (dec.nt_addr),
    .wdata (write_data),
    .rdata (nt_q)
  );

  ppubm_ram #(
    .DEPTH (ppubm_pkg::PALETTE_DEPTH),
    .WIDTH (8)
  ) u_palette (
    .clk   (clk),
    .wr_en (is_write && (dec.region == ppubm_pkg::REGION_PALETTE)),
    .rd_en (is_read && (dec.region == ppubm_pkg::REGION_PALETTE)),
    .addr  (dec.palette_addr),
    .wdata (write_data),
    .rdata (palette_q)
  );

  // pending read flag; a new read with rd_pend set coincides with a move
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else if (is_read) begin
      rd_pend <= 1'b1;
    end else if (move) begin
      rd_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      rd_region <= dec.region;
    end
  end

  // pick the store that served the pending read
  always_comb begin
    unique case (rd_region)
      ppubm_pkg::REGION_PATTERN:   rd_mux = pattern_q;
      ppubm_pkg::REGION_NAMETABLE: rd_mux = nt_q;
      ppubm_pkg::REGION_PALETTE:   rd_mux = palette_q;
      default:                     rd_mux = pattern_q;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      read_data <= rd_mux;
    end
  end

endmodule

// ----- rtl/core/ppubm_checker.sv -----
// port-level checks for the ppu video-bus memory map, bound to the top level
module ppubm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       req_type,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data))
    else $error("stalled read data changed");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // a read taken with out_valid low reaches the output after the ram register
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_type == ppubm_pkg::REQ_READ) && !out_valid
    |=> ##1 out_valid)
    else $error("read result missing");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind ppu_bus_memory_map ppubm_checker u_ppubm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .req_type  (req_type),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .read_data (read_data)
);

// ----- dv/testbench.sv -----
// self-checking testbench for the ppu video-bus memory map
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 3;
  // read path latency, used to pad the drain waits
  localparam int READ_LATENCY    = 2;
  // longest idle or stall either side draws for one transaction
  localparam int MAX_GAP         = 13;
  // cycles without a transaction on either channel before the watchdog fails the run
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int ITEMS_PER_PHASE = 360;

  // location of one byte in the three stores
  typedef struct {
    ppubm_pkg::region_t region;
    int unsigned        index;
  } vram_loc_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write_en;
  logic        vertical_mirroring;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  read_data;

  // shadow copy of the video memory and of the mirroring register
  logic [7:0]  pattern_mem  [ppubm_pkg::PATTERN_DEPTH];
  logic [7:0]  nt_mem       [ppubm_pkg::NT_DEPTH];
  logic [7:0]  palette_mem  [ppubm_pkg::PALETTE_DEPTH];
  bit          pattern_seen [ppubm_pkg::PATTERN_DEPTH];
  bit          nt_seen      [ppubm_pkg::NT_DEPTH];
  bit          palette_seen [ppubm_pkg::PALETTE_DEPTH];
  logic        mirror_vertical;

  // bytes that outstanding reads must return, oldest first
  logic [7:0]  read_data_expected [$];
  // raw addresses of every write, used to aim reads at written bytes
  logic [15:0] written_addrs [$];

  // when set, neither side idles or stalls
  bit          steady_flow;
  int          failures;
  int          writes_done;
  int          reads_done;
  int          results_checked;
  int          cfg_writes;
  int          stuck_cycles;
  logic [7:0]  want;

  always #(CLK_PERIOD / 2) clk = ~clk;

  ppu_bus_memory_map i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_write_en       (cfg_write_en),
    .vertical_mirroring (vertical_mirroring),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .req_type           (req_type),
    .address            (address),
    .write_data         (write_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .read_data          (read_data)
  );

  // fold the address to 14 bits, then map it onto one store entry
  function automatic vram_loc_t decode_vram(logic [15:0] addr, logic vert);
    vram_loc_t   loc;
    logic [13:0] bus;
    logic        tbl;
    bus = addr[ppubm_pkg::BUS_W-1:0];
    if (bus >= ppubm_pkg::PALETTE_BASE) begin
      // 32 distinct bytes, no background aliasing at 0x3f10 and friends
      loc.region = ppubm_pkg::REGION_PALETTE;
      loc.index  = 32'(bus[ppubm_pkg::PALETTE_AW-1:0]);
    end else begin
      // 0x3000-0x3eff mirrors the nametable window
      if (bus >= ppubm_pkg::FOLD_BASE) bus = bus - ppubm_pkg::FOLD_STEP;
      if (bus >= ppubm_pkg::NT_BASE) begin
        // vertical: quadrant bit 0 picks the table, horizontal: bit 1
        tbl        = vert ? bus[10] : bus[11];
        loc.region = ppubm_pkg::REGION_NAMETABLE;
        loc.index  = 32'({tbl, bus[ppubm_pkg::NT_OFS_W-1:0]});
      end else begin
        loc.region = ppubm_pkg::REGION_PATTERN;
        loc.index  = 32'(bus[ppubm_pkg::PATTERN_AW-1:0]);
      end
    end
    return loc;
  endfunction

  function automatic bit entry_written(vram_loc_t loc);
    case (loc.region)
      ppubm_pkg::REGION_PATTERN:   return pattern_seen[loc.index];
      ppubm_pkg::REGION_NAMETABLE: return nt_seen[loc.index];
      default:                     return palette_seen[loc.index];
    endcase
  endfunction

  // update the shadow memory for one accepted transaction
  function automatic void apply_access(logic req, logic [15:0] addr,
                                       logic [7:0] data);
    vram_loc_t loc;
    loc = decode_vram(addr, mirror_vertical);
    if (req == ppubm_pkg::REQ_WRITE) begin
      case (loc.region)
        ppubm_pkg::REGION_PATTERN: begin
          pattern_mem[loc.index]  = data;
          pattern_seen[loc.index] = 1'b1;
        end
        ppubm_pkg::REGION_NAMETABLE: begin
          nt_mem[loc.index]  = data;
          nt_seen[loc.index] = 1'b1;
        end
        default: begin
          palette_mem[loc.index]  = data;
          palette_seen[loc.index] = 1'b1;
        end
      endcase
      written_addrs.push_back(addr);
      writes_done++;
    end else begin
      // stimulus must never read a byte that was never written
      if (!entry_written(loc)) begin
        $error("stimulus read an unwritten byte at address %h", addr);
        failures++;
      end
      case (loc.region)
        ppubm_pkg::REGION_PATTERN:
          read_data_expected.push_back(pattern_mem[loc.index]);
        ppubm_pkg::REGION_NAMETABLE:
          read_data_expected.push_back(nt_mem[loc.index]);
        default:
          read_data_expected.push_back(palette_mem[loc.index]);
      endcase
      reads_done++;
    end
  endfunction

  function automatic int draw_gap();
    return steady_flow ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // present one transaction after a random idle gap and hold it until taken
  task automatic send_access(logic req, logic [15:0] addr, logic [7:0] data);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    address    <= addr;
    write_data <= data;
    do @(posedge clk); while (in_stall);
    apply_access(req, addr, data);
  endtask

  // stop sending, let every read come back, then give trailing writes time
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (read_data_expected.size() != 0) @(posedge clk);
    repeat (READ_LATENCY + 2) @(posedge clk);
  endtask

  // the register is only touched while the block is idle
  task automatic set_mirroring(logic vert);
    wait_idle();
    cfg_write_en       <= 1'b1;
    vertical_mirroring <= vert;
    @(posedge clk);
    mirror_vertical = vert;
    cfg_write_en   <= 1'b0;
    cfg_writes++;
  endtask

  // corners of each region and addresses at and above 0x4000
  task automatic test_region_extremes();
    send_access(ppubm_pkg::REQ_WRITE, 16'h0000, 8'h00);
    send_access(ppubm_pkg::REQ_WRITE, 16'h1fff, 8'hff);
    send_access(ppubm_pkg::REQ_WRITE, 16'h2000, 8'ha5);
    send_access(ppubm_pkg::REQ_WRITE, 16'h2fff, 8'h5a);
    send_access(ppubm_pkg::REQ_WRITE, 16'h3f00, 8'h3c);
    send_access(ppubm_pkg::REQ_WRITE, 16'h3f1f, 8'hc3);
    send_access(ppubm_pkg::REQ_READ,  16'h0000, 8'hff);
    send_access(ppubm_pkg::REQ_READ,  16'h1fff, 8'h00);
    send_access(ppubm_pkg::REQ_READ,  16'h2000, 8'($urandom));
    send_access(ppubm_pkg::REQ_READ,  16'h2fff, 8'($urandom));
    send_access(ppubm_pkg::REQ_READ,  16'h3f00, 8'($urandom));
    send_access(ppubm_pkg::REQ_READ,  16'h3f1f, 8'($urandom));
    // high bits dropped: fold modulo 0x4000
    send_access(ppubm_pkg::REQ_READ,  16'h4000, 8'($urandom));
    send_access(ppubm_pkg::REQ_READ,  16'hdfff, 8'($urandom));
    send_access(ppubm_pkg::REQ_READ,  16'hffff, 8'($urandom));
    wait_idle();
  endtask

  // sprite palette entries stay apart from the background ones
  task automatic test_palette_entries();
    send_access(ppubm_pkg::REQ_WRITE, 16'h3f10, 8'h11);
    send_access(ppubm_pkg::REQ_WRITE, 16'h3f14, 8'h22);
    send_access(ppubm_pkg::REQ_WRITE, 16'h3f18, 8'h44);
    send_access(ppubm_pkg::REQ_WRITE, 16'h3f1c, 8'h88);
    send_access(ppubm_pkg::REQ_READ,  16'h3f10, 8'($urandom));
    send_access(ppubm_pkg::REQ_READ,  16'h3f14, 8'($urandom));
    send_access(ppubm_pkg::REQ_READ,  16'h3f18, 8'($urandom));
    send_access(ppubm_pkg::REQ_READ,  16'h3f1c, 8'($urandom));
    send_access(ppubm_pkg::REQ_READ,  16'h3f00, 8'($urandom));
    // bits 7:5 ignored inside the palette window
    send_access(ppubm_pkg::REQ_READ,  16'h3f30, 8'($urandom));
    wait_idle();
  endtask

  // one byte per quadrant, then read every quadrant and the 0x3000 mirror
  task automatic test_nametable_mirroring(logic vert);
    set_mirroring(vert);
    send_access(ppubm_pkg::REQ_WRITE, 16'h2000, 8'h01);
    send_access(ppubm_pkg::REQ_WRITE, 16'h2400, 8'h02);
    send_access(ppubm_pkg::REQ_WRITE, 16'h2800, 8'h04);
    send_access(ppubm_pkg::REQ_WRITE, 16'h2c00, 8'h08);
    send_access(ppubm_pkg::REQ_READ,  16'h2000, 8'($urandom));
    send_access(ppubm_pkg::REQ_READ,  16'h2400, 8'($urandom));
    send_access(ppubm_pkg::REQ_READ,  16'h2800, 8'($urandom));
    send_access(ppubm_pkg::REQ_READ,  16'h2c00, 8'($urandom));
    send_access(ppubm_pkg::REQ_READ,  16'h3400, 8'($urandom));
    send_access(ppubm_pkg::REQ_READ,  16'h7c00, 8'($urandom));
    wait_idle();
  endtask

  // mixed traffic; reads are aimed at bytes already written through aliases
  task automatic test_random_traffic(logic vert, int count);
    logic        req;
    logic [15:0] addr;
    logic [15:0] base;
    vram_loc_t   loc;
    set_mirroring(vert);
    for (int i = 0; i < count; i++) begin
      // a stretch of back-to-back traffic in every 120 transactions
      steady_flow = (i % 120) >= 100;
      req = $urandom_range(0, 1) ? ppubm_pkg::REQ_READ : ppubm_pkg::REQ_WRITE;
      if (req == ppubm_pkg::REQ_READ && written_addrs.size() != 0 &&
          $urandom_range(0, 4) != 0) begin
        base = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
        addr = {2'($urandom), base[13:0]};
        if (addr[13:0] >= ppubm_pkg::PALETTE_BASE) begin
          addr[7:5] = 3'($urandom);
        end else if (addr[13:12] == 2'b10 && addr[11:8] != 4'hf &&
                     $urandom_range(0, 1)) begin
          addr[13:0] = addr[13:0] + ppubm_pkg::FOLD_STEP;
        end else if (addr[13:12] == 2'b11 && $urandom_range(0, 1)) begin
          addr[13:0] = addr[13:0] - ppubm_pkg::FOLD_STEP;
        end
      end else begin
        case ($urandom_range(0, 3))
          0: addr = 16'($urandom);
          1: addr = {2'($urandom), 1'b0, 13'($urandom)};
          2: addr = {2'($urandom),
                     ppubm_pkg::NT_BASE + 14'($urandom_range(0, 14'h1eff))};
          default: addr = {2'($urandom), ppubm_pkg::PALETTE_BASE[13:8],
                           8'($urandom)};
        endcase
      end
      // a read of a never-written byte turns into a write of it
      loc = decode_vram(addr, mirror_vertical);
      if (req == ppubm_pkg::REQ_READ && !entry_written(loc)) begin
        req = ppubm_pkg::REQ_WRITE;
      end
      send_access(req, addr, 8'($urandom));
    end
    steady_flow = 1'b0;
    wait_idle();
  endtask

  // output side: random stall before each result
  initial begin
    int stall_len;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall_len = draw_gap();
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // compare each accepted read result with the oldest expected byte
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (read_data_expected.size() == 0) begin
        $error("read_data transaction with nothing expected: actual %h", read_data);
        failures++;
      end else begin
        want = read_data_expected.pop_front();
        results_checked++;
        if (read_data !== want) begin
          $error("read_data mismatch: expected %h, actual %h", want, read_data);
          failures++;
        end
      end
    end
  end

  // watchdog: too long without a transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst                <= 1'b1;
    cfg_write_en       <= 1'b0;
    vertical_mirroring <= 1'b0;
    in_valid           <= 1'b0;
    req_type           <= ppubm_pkg::REQ_READ;
    address            <= '0;
    write_data         <= '0;
    mirror_vertical     = 1'b0;
    steady_flow         = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // register left at its reset value (horizontal) for the first tests
    test_region_extremes();
    test_palette_entries();
    test_nametable_mirroring(1'b1);
    test_nametable_mirroring(1'b0);
    test_random_traffic(1'b1, ITEMS_PER_PHASE);
    test_random_traffic(1'b0, ITEMS_PER_PHASE);
    test_random_traffic(1'b1, ITEMS_PER_PHASE);
    test_random_traffic(1'b0, ITEMS_PER_PHASE);

    wait_idle();
    repeat (READ_LATENCY * 4) @(posedge clk);
    if (read_data_expected.size() != 0) begin
      $error("%0d read results never arrived", read_data_expected.size());
      failures++;
    end

    $display("covered %0d writes and %0d reads over all regions, %0d results compared",
             writes_done, reads_done, results_checked);
    $display("mirroring register written %0d times, both modes, %0d failures",
             cfg_writes, failures);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ppubm_pkg.sv
rtl/core/ppubm_ram.sv
rtl/core/ppubm_decode.sv
rtl/core/ppu_bus_memory_map.sv
rtl/core/ppubm_checker.sv
dv/testbench.sv
